### src/shape_bounding_box_defines.svh
// assertion macros shared by the bounding box checker
`ifndef SHAPE_BOUNDING_BOX_DEFINES_SVH
`define SHAPE_BOUNDING_BOX_DEFINES_SVH

// same-cycle implication
`define SBB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SBB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/sbb_pkg.sv
// shared types, codes and constants of the bounding box block
package sbb_pkg;

    localparam int MAX_VERTICES = 256;
    localparam int MIN_VERTICES = 3;
    localparam int VCNT_W       = $clog2(MAX_VERTICES + 1);
    localparam int DIV_STEPS    = 33;
    localparam int DCNT_W       = $clog2(DIV_STEPS);

    localparam logic [1:0] KIND_SQUARE  = 2'd0;
    localparam logic [1:0] KIND_CIRCLE  = 2'd1;
    localparam logic [1:0] KIND_POLYGON = 2'd2;

    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
    localparam logic [32:0] HALF_PI_Q32 = 33'd6746518852;

    // reciprocals for exact division of values below 2^30
    localparam logic [32:0] RCP_42 = 33'd1636178018;
    localparam logic [32:0] RCP_20 = 33'd1717986919;
    localparam logic [32:0] RCP_6  = 33'd1431655766;
    localparam logic [32:0] RCP_56 = 33'd1227133514;
    localparam logic [32:0] RCP_30 = 33'd1145324613;
    localparam logic [32:0] RCP_12 = 33'd1431655766;

    // datapath operations, in issue order
    localparam logic [4:0] OP_TH   = 5'd0;
    localparam logic [4:0] OP_X2   = 5'd1;
    localparam logic [4:0] OP_D42  = 5'd2;
    localparam logic [4:0] OP_PT0  = 5'd3;
    localparam logic [4:0] OP_D20  = 5'd4;
    localparam logic [4:0] OP_PT1  = 5'd5;
    localparam logic [4:0] OP_D6   = 5'd6;
    localparam logic [4:0] OP_SIN  = 5'd7;
    localparam logic [4:0] OP_D56  = 5'd8;
    localparam logic [4:0] OP_PT2  = 5'd9;
    localparam logic [4:0] OP_D30  = 5'd10;
    localparam logic [4:0] OP_PT3  = 5'd11;
    localparam logic [4:0] OP_D12  = 5'd12;
    localparam logic [4:0] OP_PT4  = 5'd13;
    localparam logic [4:0] OP_COSH = 5'd14;
    localparam logic [4:0] OP_VX   = 5'd15;
    localparam logic [4:0] OP_VY   = 5'd16;

    typedef struct packed {
        logic       load;
        logic       setup;
        logic       div_step;
        logic       vprep;
        logic       mul;
        logic       wb;
        logic       upd;
        logic       advance;
        logic       fin;
        logic [4:0] op;
    } sbb_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       rad_zero;
        logic       last_vertex;
    } sbb_status_t;

    function automatic logic [31:0] sat32(input logic signed [33:0] v);
        logic [31:0] r;
        if (v > 34'sh0_7FFF_FFFF)
            r = 32'h7FFF_FFFF;
        else if (v < -34'sh0_8000_0000)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

### src/sbb_ctrl.sv
// controller state machine of the bounding box block
module sbb_ctrl
    import sbb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  sbb_status_t status,
    output sbb_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_VPREP = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_WB    = 3'd5;
    localparam logic [2:0] S_UPD   = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [4:0]        op_reg, op_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        cnt_next       = cnt_reg;
        cmd            = '0;
        cmd.op         = op_reg;
        out_valid_next = (out_valid_reg && m_tready) ? 1'b0 : out_valid_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                cmd.setup = 1'b1;
                cnt_next  = '0;
                if (status.kind == KIND_POLYGON && !status.rad_zero)
                    state_next = S_DIV;
                else
                    state_next = S_FIN;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DCNT_W'(DIV_STEPS - 1))
                    state_next = S_VPREP;
            end
            S_VPREP:
            begin
                cmd.vprep  = 1'b1;
                op_next    = OP_TH;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_WB;
            end
            S_WB:
            begin
                cmd.wb = 1'b1;
                if (op_reg == OP_VY)
                    state_next = S_UPD;
                else
                begin
                    op_next    = op_reg + 1'b1;
                    state_next = S_MUL;
                end
            end
            S_UPD:
            begin
                cmd.upd = 1'b1;
                if (status.last_vertex)
                    state_next = S_FIN;
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_VPREP;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.fin        = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_TH;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### src/sbb_datapath.sv
// datapath: input registers, step divider, shared multiplier, extremes and result registers
module sbb_datapath
    import sbb_pkg::*;
(
    input  logic         clk,
    input  logic [191:0] s_tdata,
    input  logic [1:0]   s_tuser,
    input  sbb_cmd_t     cmd,
    output sbb_status_t  status,
    output logic [127:0] m_tdata,
    output logic         m_tuser
);

    logic [1:0]          kind_reg;
    logic signed [31:0]  ox_reg, oy_reg, sx_reg, sy_reg, rad_reg;
    logic [15:0]         start_reg;
    logic [8:0]          req_reg;

    logic [VCNT_W-1:0]   n_reg, i_reg;
    logic [32:0]         dvd_reg;
    logic [VCNT_W-1:0]   rem_reg;
    logic [31:0]         quo_reg;
    logic [31:0]         accq_reg;
    logic [VCNT_W-1:0]   accr_reg;

    logic [1:0]          quad_reg;
    logic                swap_reg;
    logic [29:0]         fsel_reg;
    logic [65:0]         prod_reg;
    logic [29:0]         th_reg, x2_reg, p_reg;
    logic [30:0]         t_reg, sv_reg, cv_reg;
    logic [31:0]         vxm_reg, vym_reg;
    logic signed [32:0]  mnx_reg, mxx_reg, mny_reg, mxy_reg;

    logic [31:0]         left_reg, top_reg, right_reg, bottom_reg;
    logic                empty_reg;

    logic [31:0]         ar, asx, asy;
    logic [30:0]         hx, hy;
    logic [VCNT_W-1:0]   n_clamp;
    logic [VCNT_W:0]     rem_sh, r_sum;
    logic [31:0]         ang;
    logic [30:0]         sf_mag, cf_mag, s_mag, c_mag;
    logic                s_neg, c_neg;
    logic [32:0]         op_a, op_b;
    logic signed [32:0]  vx, vy;
    logic [65:0]         rnd_x, rnd_y;
    logic                empty;

    assign ar  = rad_reg[31] ? (~rad_reg + 32'd1) : rad_reg;
    assign asx = sx_reg[31] ? (~sx_reg + 32'd1) : sx_reg;
    assign asy = sy_reg[31] ? (~sy_reg + 32'd1) : sy_reg;
    assign hx  = asx[31:1];
    assign hy  = asy[31:1];

    always_comb
    begin
        if (req_reg < 9'(MIN_VERTICES))
            n_clamp = VCNT_W'(MIN_VERTICES);
        else if (VCNT_W'(req_reg) > VCNT_W'(MAX_VERTICES))
            n_clamp = VCNT_W'(MAX_VERTICES);
        else
            n_clamp = VCNT_W'(req_reg);
    end

    assign rem_sh = {rem_reg, dvd_reg[32]};
    assign r_sum  = {1'b0, accr_reg} + {1'b0, rem_reg};
    assign ang    = {start_reg, 16'h0000} + accq_reg;

    assign sf_mag = swap_reg ? cv_reg : sv_reg;
    assign cf_mag = swap_reg ? sv_reg : cv_reg;
    assign s_mag  = quad_reg[0] ? cf_mag : sf_mag;
    assign c_mag  = quad_reg[0] ? sf_mag : cf_mag;
    assign s_neg  = quad_reg[1];
    assign c_neg  = quad_reg[1] ^ quad_reg[0];

    assign vx = c_neg ? -$signed({1'b0, vxm_reg}) : $signed({1'b0, vxm_reg});
    assign vy = s_neg ? -$signed({1'b0, vym_reg}) : $signed({1'b0, vym_reg});

    assign rnd_x = prod_reg + 66'h2000_0000;
    assign rnd_y = prod_reg + 66'h2000_0000;

    assign empty = (kind_reg == 2'd3) || (kind_reg == KIND_POLYGON && rad_reg == 32'sd0);

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (cmd.op)
            OP_TH:   begin op_a = {3'b000, fsel_reg}; op_b = HALF_PI_Q32;        end
            OP_X2:   begin op_a = {3'b000, th_reg};   op_b = {3'b000, th_reg};   end
            OP_D42:  begin op_a = {3'b000, x2_reg};   op_b = RCP_42;             end
            OP_D56:  begin op_a = {3'b000, x2_reg};   op_b = RCP_56;             end
            OP_D20:  begin op_a = {3'b000, p_reg};    op_b = RCP_20;             end
            OP_D6:   begin op_a = {3'b000, p_reg};    op_b = RCP_6;              end
            OP_D30:  begin op_a = {3'b000, p_reg};    op_b = RCP_30;             end
            OP_D12:  begin op_a = {3'b000, p_reg};    op_b = RCP_12;             end
            OP_PT0, OP_PT1, OP_PT2, OP_PT3, OP_PT4:
                     begin op_a = {3'b000, x2_reg};   op_b = {2'b00, t_reg};     end
            OP_SIN:  begin op_a = {3'b000, th_reg};   op_b = {2'b00, t_reg};     end
            OP_VX:   begin op_a = {1'b0, ar};         op_b = {2'b00, c_mag};     end
            OP_VY:   begin op_a = {1'b0, ar};         op_b = {2'b00, s_mag};     end
            default: begin op_a = '0;                 op_b = '0;                 end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= s_tuser;
            ox_reg    <= s_tdata[31:0];
            oy_reg    <= s_tdata[63:32];
            sx_reg    <= s_tdata[95:64];
            sy_reg    <= s_tdata[127:96];
            rad_reg   <= s_tdata[159:128];
            start_reg <= s_tdata[175:160];
            req_reg   <= s_tdata[184:176];
        end

        if (cmd.setup)
        begin
            n_reg    <= n_clamp;
            i_reg    <= '0;
            dvd_reg  <= 33'h1_0000_0000;
            rem_reg  <= '0;
            quo_reg  <= '0;
            accq_reg <= '0;
            accr_reg <= '0;
            if (kind_reg == KIND_SQUARE)
            begin
                mnx_reg <= -$signed({2'b00, hx});
                mxx_reg <= $signed({2'b00, hx});
                mny_reg <= -$signed({2'b00, hy});
                mxy_reg <= $signed({2'b00, hy});
            end
            else
            begin
                mnx_reg <= -$signed({1'b0, ar});
                mxx_reg <= $signed({1'b0, ar});
                mny_reg <= -$signed({1'b0, ar});
                mxy_reg <= $signed({1'b0, ar});
            end
        end

        if (cmd.div_step)
        begin
            dvd_reg <= {dvd_reg[31:0], 1'b0};
            if (rem_sh >= {1'b0, n_reg})
            begin
                rem_reg <= VCNT_W'(rem_sh - {1'b0, n_reg});
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= VCNT_W'(rem_sh);
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end

        if (cmd.vprep)
        begin
            quad_reg <= ang[31:30];
            swap_reg <= ang[29];
            fsel_reg <= ang[29] ? 30'(31'h4000_0000 - {1'b0, ang[29:0]}) : ang[29:0];
        end

        if (cmd.mul)
            prod_reg <= op_a * op_b;

        if (cmd.wb)
        begin
            case (cmd.op)
                OP_TH:   th_reg  <= prod_reg[61:32];
                OP_X2:   x2_reg  <= prod_reg[59:30];
                OP_D42:  t_reg   <= Q30_ONE - 31'(prod_reg >> 36);
                OP_D20:  t_reg   <= Q30_ONE - 31'(prod_reg >> 35);
                OP_D6:   t_reg   <= Q30_ONE - 31'(prod_reg >> 33);
                OP_D56:  t_reg   <= Q30_ONE - 31'(prod_reg >> 36);
                OP_D30:  t_reg   <= Q30_ONE - 31'(prod_reg >> 35);
                OP_D12:  t_reg   <= Q30_ONE - 31'(prod_reg >> 34);
                OP_PT0, OP_PT1, OP_PT2, OP_PT3, OP_PT4:
                         p_reg   <= prod_reg[59:30];
                OP_SIN:  sv_reg  <= prod_reg[60:30];
                OP_COSH: cv_reg  <= Q30_ONE - {2'b00, p_reg[29:1]};
                OP_VX:   vxm_reg <= rnd_x[61:30];
                OP_VY:   vym_reg <= rnd_y[61:30];
                default: ;
            endcase
        end

        if (cmd.upd)
        begin
            if (i_reg == '0)
            begin
                mnx_reg <= vx;
                mxx_reg <= vx;
                mny_reg <= vy;
                mxy_reg <= vy;
            end
            else
            begin
                if (vx < mnx_reg) mnx_reg <= vx;
                if (vx > mxx_reg) mxx_reg <= vx;
                if (vy < mny_reg) mny_reg <= vy;
                if (vy > mxy_reg) mxy_reg <= vy;
            end
        end

        if (cmd.advance)
        begin
            i_reg <= i_reg + 1'b1;
            if (r_sum >= {1'b0, n_reg})
            begin
                accr_reg <= VCNT_W'(r_sum - {1'b0, n_reg});
                accq_reg <= accq_reg + quo_reg + 32'd1;
            end
            else
            begin
                accr_reg <= VCNT_W'(r_sum);
                accq_reg <= accq_reg + quo_reg;
            end
        end

        if (cmd.fin)
        begin
            empty_reg <= empty;
            if (empty)
            begin
                left_reg   <= '0;
                top_reg    <= '0;
                right_reg  <= '0;
                bottom_reg <= '0;
            end
            else
            begin
                left_reg   <= sat32($signed({{2{ox_reg[31]}}, ox_reg}) +
                                    $signed({mnx_reg[32], mnx_reg}));
                top_reg    <= sat32($signed({{2{oy_reg[31]}}, oy_reg}) +
                                    $signed({mny_reg[32], mny_reg}));
                right_reg  <= sat32($signed({{2{ox_reg[31]}}, ox_reg}) +
                                    $signed({mxx_reg[32], mxx_reg}));
                bottom_reg <= sat32($signed({{2{oy_reg[31]}}, oy_reg}) +
                                    $signed({mxy_reg[32], mxy_reg}));
            end
        end
    end

    assign status.kind         = kind_reg;
    assign status.rad_zero     = (rad_reg == 32'sd0);
    assign status.last_vertex  = (i_reg == n_reg - 1'b1);

    assign m_tdata = {bottom_reg, right_reg, top_reg, left_reg};
    assign m_tuser = empty_reg;

endmodule

### src/shape_bounding_box.sv
// top level of the shape bounding box block
// square, circle and empty items: m_tvalid rises after the setup and finish states
// polygon items: setup, the divider steps, then per vertex a prep, multiplier and update pass, then finish
// s_tready is high only in idle, so the next input is taken once the last item is done, later while
// a result waits on m_tready; 33-step divider, 17 multiplier ops per vertex, each a multiply and a write-back state
// reset clears the state machine and output valid; no memories need clearing
module shape_bounding_box
    import sbb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [191:0] s_tdata,  // offset_x, offset_y, size_x, size_y, radius, start_angle, vertex_count, pad
    input  logic [1:0]   s_tuser,  // kind
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,  // left, top, right, bottom
    output logic         m_tuser   // empty_res
);

    sbb_cmd_t    cmd;
    sbb_status_t status;

    sbb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sbb_datapath u_dp (
        .clk     (clk),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .cmd     (cmd),
        .status  (status),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule

### src/sbb_checker.sv
// port-level checker for the bounding box block, bound to the top level
`include "shape_bounding_box_defines.svh"

module sbb_port_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [191:0] s_tdata,
    input logic [1:0]   s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic         m_tuser
);

    `SBB_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
    `SBB_ASSERT_IMP(a_empty_zero, m_tvalid && m_tuser, m_tdata == 128'd0, "empty result with nonzero edges")
    `SBB_ASSERT_IMP(a_order, m_tvalid && !m_tuser, ($signed(m_tdata[31:0]) <= $signed(m_tdata[95:64])) && ($signed(m_tdata[63:32]) <= $signed(m_tdata[127:96])), "box edges out of order")
    `SBB_ASSERT_NXT(a_busy, s_tvalid && s_tready, !s_tready, "second transfer taken while busy")

endmodule

bind shape_bounding_box sbb_port_checker u_sbb_checker (.*);

### tb/sv/sbb_checker.sv
// checker for the bounding box block: predicts each box and compares the results
module sbb_checker
    import sbb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [191:0] s_tdata,  // offset_x, offset_y, size_x, size_y, radius, start_angle, vertex_count, pad
    input  logic [1:0]   s_tuser,  // kind
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [127:0] m_tdata,  // left, top, right, bottom
    input  logic         m_tuser,  // empty_res
    output int           mismatches,
    output int           boxes_due,
    output logic         transfer_seen
);

    typedef bit [63:0] u64_t;

    typedef struct {
        bit [31:0] left;
        bit [31:0] top;
        bit [31:0] right;
        bit [31:0] bottom;
        bit        empty;
    } box_t;

    localparam u64_t ONE_Q30   = 64'd1 << 30;
    localparam u64_t QUARTER_T = 64'd6746518852;

    box_t due_boxes[$];

    function automatic u64_t qmul(input u64_t a, input u64_t b);
        return (a * b) >> 30;
    endfunction

    function automatic u64_t sin_series(input u64_t x);
        u64_t x2, t;
        x2 = qmul(x, x);
        t = ONE_Q30 - x2 / 42;
        t = ONE_Q30 - qmul(x2, t) / 20;
        t = ONE_Q30 - qmul(x2, t) / 6;
        return qmul(x, t);
    endfunction

    function automatic u64_t cos_series(input u64_t x);
        u64_t x2, t;
        x2 = qmul(x, x);
        t = ONE_Q30 - x2 / 56;
        t = ONE_Q30 - qmul(x2, t) / 30;
        t = ONE_Q30 - qmul(x2, t) / 12;
        t = ONE_Q30 - qmul(x2, t) / 2;
        return t;
    endfunction

    function automatic void turn_sincos(input bit [31:0] ang, output longint s,
                                        output longint c);
        u64_t f, th;
        longint sf, cf;
        f = {34'd0, ang[29:0]};
        if (f < (64'd1 << 29))
        begin
            th = (f * QUARTER_T) >> 32;
            sf = longint'(sin_series(th));
            cf = longint'(cos_series(th));
        end
        else
        begin
            th = ((ONE_Q30 - f) * QUARTER_T) >> 32;
            sf = longint'(cos_series(th));
            cf = longint'(sin_series(th));
        end
        case (ang[31:30])
            2'd0:
            begin
                s = sf;  c = cf;
            end
            2'd1:
            begin
                s = cf;  c = -sf;
            end
            2'd2:
            begin
                s = -sf; c = -cf;
            end
            default:
            begin
                s = -cf; c = sf;
            end
        endcase
    endfunction

    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint scaled(input longint r, input longint v);
        longint m;
        m = longint'((u64_t'(r) * u64_t'(magnitude(v)) + (64'd1 << 29)) >> 30);
        return (v < 0) ? -m : m;
    endfunction

    function automatic bit [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic box_t shape_box(input logic [1:0] kind, input logic [191:0] d);
        box_t bx;
        longint ox, oy, hx, hy, ar, s, c, vx, vy, mnx, mny, mxx, mxy;
        int n;
        bit [31:0] step, ang;
        ox = longint'($signed(d[31:0]));
        oy = longint'($signed(d[63:32]));
        bx = '{32'd0, 32'd0, 32'd0, 32'd0, 1'b0};
        ar = magnitude(longint'($signed(d[159:128])));
        if (kind == KIND_SQUARE || kind == KIND_CIRCLE)
        begin
            hx = (kind == KIND_SQUARE) ? magnitude(longint'($signed(d[95:64]))) >>> 1 : ar;
            hy = (kind == KIND_SQUARE) ? magnitude(longint'($signed(d[127:96]))) >>> 1 : ar;
            bx.left   = clamp32(ox - hx);
            bx.top    = clamp32(oy - hy);
            bx.right  = clamp32(ox + hx);
            bx.bottom = clamp32(oy + hy);
        end
        else if (kind == KIND_POLYGON && ar != 0)
        begin
            n = int'(d[184:176]);
            if (n < MIN_VERTICES)
                n = MIN_VERTICES;
            if (n > MAX_VERTICES)
                n = MAX_VERTICES;
            mnx = 0; mny = 0; mxx = 0; mxy = 0;
            for (int i = 0; i < n; i++)
            begin
                step = 32'((u64_t'(i) << 32) / u64_t'(n));
                ang = {d[175:160], 16'd0} + step;
                turn_sincos(ang, s, c);
                vx = scaled(ar, c);
                vy = scaled(ar, s);
                if (i == 0)
                begin
                    mnx = vx; mxx = vx; mny = vy; mxy = vy;
                end
                else
                begin
                    if (vx < mnx) mnx = vx;
                    if (vx > mxx) mxx = vx;
                    if (vy < mny) mny = vy;
                    if (vy > mxy) mxy = vy;
                end
            end
            bx.left   = clamp32(ox + mnx);
            bx.top    = clamp32(oy + mny);
            bx.right  = clamp32(ox + mxx);
            bx.bottom = clamp32(oy + mxy);
        end
        else
            bx.empty = 1'b1;
        return bx;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        box_t want;
        if (!rst_n)
        begin
            mismatches    <= 0;
            boxes_due     <= 0;
            transfer_seen <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                due_boxes.push_back(shape_box(s_tuser, s_tdata));
            if (m_tvalid && m_tready)
            begin
                if (due_boxes.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected result transfer: %h empty %b", m_tdata, m_tuser);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = due_boxes.pop_front();
                    if (m_tdata !== {want.bottom, want.right, want.top, want.left}
                        || m_tuser !== want.empty)
                    begin
                        if (mismatches < 10)
                            $display("box mismatch: expected l %h t %h r %h b %h e %b, got %h %b",
                                     want.left, want.top, want.right, want.bottom, want.empty,
                                     m_tdata, m_tuser);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            boxes_due     <= due_boxes.size();
            transfer_seen <= (s_tvalid && s_tready) || (m_tvalid && m_tready);
        end
    end

endmodule

### tb/sv/tb_shape_bounding_box.sv
// testbench top for the shape bounding box block: stimulus, watchdog and verdict
module tb_shape_bounding_box;
    import sbb_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 60000;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [191:0] s_tdata;  // offset_x, offset_y, size_x, size_y, radius, start_angle, vertex_count, pad
    logic [1:0]   s_tuser;  // kind
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;  // left, top, right, bottom
    logic         m_tuser;  // empty_res

    int   mismatches;
    int   boxes_due;
    logic transfer_seen;
    int   send_idle;
    int   recv_stall;
    bit   hold_req;
    int   quiet_cycles;

    shape_bounding_box i_dut (.*);

    sbb_checker i_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .mismatches(mismatches), .boxes_due(boxes_due), .transfer_seen(transfer_seen)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    task automatic send_shape(input logic [1:0] kind, input logic [31:0] ox,
                              input logic [31:0] oy, input logic [31:0] sx,
                              input logic [31:0] sy, input logic [31:0] rad,
                              input logic [15:0] ang, input logic [8:0] cnt);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {7'd0, cnt, ang, rad, sy, sx, oy, ox};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic send_random_shape();
        logic [1:0] kind;
        logic [8:0] cnt;
        logic [31:0] rad;
        kind = ($urandom_range(0, 49) == 0) ? KIND_UNUSED : 2'($urandom_range(0, 2));
        cnt = ($urandom_range(0, 19) == 0) ? 9'($urandom_range(0, 511))
                                           : 9'($urandom_range(0, 12));
        case ($urandom_range(0, 3))
            0:       rad = $urandom;
            1:       rad = $urandom_range(0, 32'h0010_0000);
            2:       rad = -$urandom_range(0, 32'h0010_0000);
            default: rad = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom_range(1, 255);
        endcase
        send_shape(kind, $urandom, $urandom, $urandom, $urandom, rad, 16'($urandom), cnt);
    endtask

    // receiver, with an optional long hold-off
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                repeat (400)
                begin
                    m_tready <= 1'b0;
                    @(negedge clk);
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_stall);
        end
    end

    // watchdog on cycles without any transfer
    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            quiet_cycles = transfer_seen ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int idle_sets[4][2];
        idle_sets = '{'{0, 0}, '{78, 0}, '{0, 78}, '{21, 21}};
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = KIND_SQUARE;
        send_idle  = 0;
        recv_stall = 0;
        hold_req   = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // extremes and special cases
        send_shape(KIND_SQUARE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 16'h0, 9'd0);
        send_shape(KIND_SQUARE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h0, 16'hFFFF, 9'h1FF);
        send_shape(KIND_SQUARE, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0001_0000,
                   32'h0, 16'h0, 9'd0);
        send_shape(KIND_CIRCLE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 16'h0, 9'd0);
        send_shape(KIND_CIRCLE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0,
                   32'h8000_0000, 16'h0, 9'd0);
        send_shape(KIND_CIRCLE, 32'hFFFF_0000, 32'h0001_0000, 32'h0, 32'h0,
                   32'h7FFF_FFFF, 16'h0, 9'd0);
        send_shape(KIND_POLYGON, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 16'h0, 9'd4);
        send_shape(KIND_POLYGON, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 16'h0, 9'd0);
        send_shape(KIND_POLYGON, 32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF_0000, 16'h4000, 9'd1);
        send_shape(KIND_POLYGON, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 16'h2000, 9'd2);
        send_shape(KIND_POLYGON, 32'h1234_5678, 32'h0, 32'h0, 32'h0, 32'h0001_0000,
                   16'hFFFF, 9'd3);
        send_shape(KIND_POLYGON, 32'h0, 32'h0, 32'h0, 32'h0, 32'h8000_0000, 16'h8000, 9'd4);
        send_shape(KIND_POLYGON, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 32'h7FFF_FFFF,
                   16'h0, 9'd6);
        send_shape(KIND_POLYGON, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0000_0001, 16'h1000, 9'd256);
        send_shape(KIND_POLYGON, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0100_0000, 16'h0, 9'd257);
        send_shape(KIND_POLYGON, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0100_0000, 16'h0, 9'h1FF);
        send_shape(KIND_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 16'hFFFF, 9'h1FF);

        // receiver holds off while squares keep coming
        hold_req = 1'b1;
        repeat (10)
            send_shape(KIND_SQUARE, $urandom, $urandom, $urandom, $urandom, $urandom,
                       16'($urandom), 9'($urandom));

        for (int p = 0; p < 4; p++)
        begin
            send_idle  = idle_sets[p][0];
            recv_stall = idle_sets[p][1];
            repeat (150)
                send_random_shape();
        end
        @(negedge clk);
        s_tvalid <= 1'b0;

        while (boxes_due != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && boxes_due == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
